// ===== src/fcw_pkg.sv =====
`timescale 1ns / 1ps
package fcw_pkg;

    localparam int FAT_ENTRIES_DEF = 4096;
    localparam int MAX_CHAIN_DEF   = 64;

    localparam logic [15:0] END_MARK  = 16'hFFF8;
    localparam logic [15:0] FIRST_CLU = 16'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_WALK  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BROKEN    = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_WIDX      = 3'd4
    } t_status;

    typedef struct packed {
        logic accept;
        logic emit_resp;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic short_item;
        logic out_free;
        logic walk_cont;
    } t_stat;

endpackage

// ===== src/fat16_cluster_chain_walk_core.sv =====
`timescale 1ns / 1ps
// FAT16 cluster chain walker. Write requests (func 0) load one allocation table
// entry each (none if the index is out of range) and return one acknowledge
// result; walk requests (func 1) return the start cluster and every following
// cluster in chain order, with last set on the final one and status telling
// how the chain ended (a bad start returns one result). The table sits in a
// single-port-write, registered-read memory of FAT_ENTRIES words; entries
// must be written before a walk reaches them. A walk does one table read per
// cluster and returns at most MAX_CHAIN clusters. One request is processed at
// a time; the output register lets the next request in while a result waits.
module fat16_cluster_chain_walk_core #(
    parameter int FAT_ENTRIES = fcw_pkg::FAT_ENTRIES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [15:0] i_cluster_index,
    input  logic [15:0] i_entry_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_cluster,
    output logic        o_last,
    output logic [2:0]  o_status
);
    import fcw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fcw_datapath #(
        .FAT_ENTRIES (FAT_ENTRIES),
        .MAX_CHAIN   (MAX_CHAIN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_func),
        .i_cluster_index (i_cluster_index),
        .i_entry_value   (i_entry_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cluster       (o_cluster),
        .o_last          (o_last),
        .o_status        (o_status)
    );

endmodule

// ===== src/fcw_ctrl.sv =====
`timescale 1ns / 1ps
module fcw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fcw_pkg::t_stat i_stat,
    output fcw_pkg::t_cmd  o_cmd
);
    import fcw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RESP = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_ready          = (r_state == S_IDLE);
        o_cmd.accept     = i_valid && (r_state == S_IDLE);
        o_cmd.emit_resp  = (r_state == S_RESP) && i_stat.out_free;
        o_cmd.step       = (r_state == S_WALK) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_stat.short_item ? S_RESP : S_WALK;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.out_free && !i_stat.walk_cont) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/fcw_datapath.sv =====
`timescale 1ns / 1ps
module fcw_datapath #(
    parameter int FAT_ENTRIES = fcw_pkg::FAT_ENTRIES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fcw_pkg::t_cmd  i_cmd,
    output fcw_pkg::t_stat o_stat,
    input  logic           i_func,
    input  logic [15:0]    i_cluster_index,
    input  logic [15:0]    i_entry_value,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_cluster,
    output logic           o_last,
    output logic [2:0]     o_status
);
    import fcw_pkg::*;

    localparam int          AW    = $clog2(FAT_ENTRIES);
    localparam int          CW    = $clog2(MAX_CHAIN + 1);
    localparam logic [16:0] LIMIT = 17'(FAT_ENTRIES);

    logic [15:0]   mem [FAT_ENTRIES];
    logic [15:0]   r_rd_data;
    logic [15:0]   r_cur;
    logic [CW-1:0] r_cnt;
    t_status       r_status;

    logic          r_out_valid;
    logic [15:0]   r_out_cluster;
    logic          r_out_last;
    t_status       r_out_status;

    logic          idx_in_range;
    logic          start_bad;
    logic          link_end;
    logic          link_broken;
    logic          walk_cont;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_status       walk_status;

    always_comb begin
        idx_in_range = {1'b0, i_cluster_index} < LIMIT;
        start_bad    = (i_cluster_index < FIRST_CLU) || (i_cluster_index >= END_MARK)
                       || !idx_in_range;
        link_end     = r_rd_data >= END_MARK;
        link_broken  = (r_rd_data < FIRST_CLU) || ({1'b0, r_rd_data} >= LIMIT);
        walk_cont    = !link_end && !link_broken && (r_cnt < CW'(MAX_CHAIN));
        if (link_end) begin
            walk_status = ST_OK;
        end else if (link_broken) begin
            walk_status = ST_BROKEN;
        end else begin
            walk_status = ST_TRUNC;
        end

        wr_en   = i_cmd.accept && (i_func == FUNC_WRITE) && idx_in_range;
        rd_en   = (i_cmd.accept && (i_func == FUNC_WALK)) || (i_cmd.step && walk_cont);
        rd_addr = i_cmd.accept ? i_cluster_index[AW-1:0] : r_rd_data[AW-1:0];

        o_stat.short_item = (i_func == FUNC_WRITE) || start_bad;
        o_stat.out_free   = !r_out_valid || i_ready;
        o_stat.walk_cont  = walk_cont;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_cluster_index[AW-1:0]] <= i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur <= i_cluster_index;
            r_cnt <= CW'(1);
            if (i_func == FUNC_WRITE) begin
                r_status <= idx_in_range ? ST_OK : ST_WIDX;
            end else begin
                r_status <= ST_BAD_START;
            end
        end else if (i_cmd.step && walk_cont) begin
            r_cur <= r_rd_data;
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_resp || i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_resp) begin
            r_out_cluster <= 16'd0;
            r_out_last    <= 1'b1;
            r_out_status  <= r_status;
        end else if (i_cmd.step) begin
            r_out_cluster <= r_cur;
            r_out_last    <= !walk_cont;
            r_out_status  <= walk_cont ? ST_OK : walk_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_cluster = r_out_cluster;
    assign o_last    = r_out_last;
    assign o_status  = r_out_status;

endmodule
